// File: rtl/core/icfm_pkg.sv
package icfm_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int CHANNELS_DEF      = 2;

    localparam int CLOCK_W    = 28;
    localparam int PRESC_W    = 17;
    localparam int FREQ_W     = 28;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 28;

    localparam logic [CLOCK_W-1:0] CLOCK_HZ_RST = CLOCK_W'(72000000);
    localparam logic [PRESC_W-1:0] PRESC_RST    = PRESC_W'(64);

    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LAUNCH,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// File: rtl/core/icfm_div.sv
module icfm_div #(
    parameter int NW = 28,
    parameter int DW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);
    localparam int CNT_W = (NW > 1) ? $clog2(NW) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_dvs;

    logic [DW:0]      n_trial;
    logic [DW:0]      n_diff;
    logic             n_bit;

    // one quotient bit per cycle, restoring
    always_comb begin
        n_trial = {r_rem, r_quo[NW-1]};
        n_diff  = n_trial - {1'b0, r_dvs};
        n_bit   = (n_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_bit ? n_diff[DW-1:0] : n_trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], n_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/core/input_capture_frequency_meter.sv
// Input-capture frequency meter.
// Input channel (i_valid/o_ready): one beat per capture event, carrying the
// channel number and the timer count latched at a rising edge. Each channel
// alternates: the first beat is stored and returns nothing; the second gives
// one result beat with the period, the frequency clock/prescale/period and
// an error flag set when the period or the prescale divisor is zero.
// Output channel (o_valid/i_ready): one beat per completed measurement.
// Config port: i_cfg_we with i_cfg_index selects clock_hz (0) or
// prescale_divisor (1); write only while the block is idle.
// A second-phase beat passes through the period register, the product
// prescale*period, then a bit-serial divider that yields one of the 28
// quotient bits per cycle. No new beat is taken until the result is loaded
// into the output register. A zero divisor skips the divider. While the
// receiver stalls with a result in the output register, one more
// measurement may finish and wait; input then stops until the output
// register frees.
// Reset clears all channel phases and loads clock_hz 72000000 and prescale
// divisor 64.
module input_capture_frequency_meter #(
    parameter int COUNTER_WIDTH = icfm_pkg::COUNTER_WIDTH_DEF,
    parameter int CHANNELS      = icfm_pkg::CHANNELS_DEF,
    localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [CH_W-1:0]                 i_channel,
    input  logic [COUNTER_WIDTH-1:0]        i_capture_count,
    input  logic                            i_cfg_we,
    input  logic [icfm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [icfm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [CH_W-1:0]                 o_out_channel,
    output logic [COUNTER_WIDTH-1:0]        o_period_ticks,
    output logic [icfm_pkg::FREQ_W-1:0]     o_frequency_hz,
    output logic                            o_divide_error
);
    import icfm_pkg::*;

    localparam int CW     = COUNTER_WIDTH;
    localparam int PROD_W = PRESC_W + CW;
    localparam logic [CH_W:0] CH_LIM = (CH_W + 1)'(CHANNELS);

    t_state r_state, n_state;

    logic [CLOCK_W-1:0] r_clock_hz;
    logic [PRESC_W-1:0] r_presc;
    logic [CHANNELS-1:0] r_phase;
    logic [CW-1:0]      r_first [CHANNELS];
    logic [CW-1:0]      r_period;
    logic [CH_W-1:0]    r_ch;
    logic [PROD_W-1:0]  r_prod;
    logic               r_err;
    logic               r_out_valid;
    logic [CH_W-1:0]    r_out_ch;
    logic [CW-1:0]      r_out_period;
    logic [FREQ_W-1:0]  r_out_freq;
    logic               r_out_err;

    logic               in_fire;
    logic               ch_ok;
    logic               div_start;
    logic               div_done;
    logic               out_load;
    logic [CW-1:0]      first_sel;
    logic [CW-1:0]      n_period;
    logic [FREQ_W-1:0]  quotient;

    assign in_fire   = i_valid && o_ready;
    assign ch_ok     = ({1'b0, i_channel} < CH_LIM);
    assign first_sel = r_first[i_channel];
    // (MAX - first) + cap, plus one more when cap > first
    assign n_period  = i_capture_count + ~first_sel + CW'(i_capture_count > first_sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && ch_ok && r_phase[i_channel]) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                if (r_err) begin
                    n_state = ST_OUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLOCK_HZ_RST;
            r_presc    <= PRESC_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CLOCK_HZ: r_clock_hz <= i_cfg_data[CLOCK_W-1:0];
                REG_PRESCALE: r_presc    <= i_cfg_data[PRESC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (in_fire && ch_ok) begin
            r_phase[i_channel] <= ~r_phase[i_channel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && ch_ok) begin
            if (!r_phase[i_channel]) begin
                r_first[i_channel] <= i_capture_count;
            end else begin
                r_period <= n_period;
                r_ch     <= i_channel;
            end
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_presc) * PROD_W'(r_period);
            r_err  <= (r_period == '0) || (r_presc == '0);
        end
    end

    icfm_div #(
        .NW (FREQ_W),
        .DW (PROD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_clock_hz),
        .i_divisor  (r_prod),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ch     <= r_ch;
            r_out_period <= r_period;
            r_out_freq   <= r_err ? '0 : quotient;
            r_out_err    <= r_err;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_channel  = r_out_ch;
    assign o_period_ticks = r_out_period;
    assign o_frequency_hz = r_out_freq;
    assign o_divide_error = r_out_err;

endmodule

// File: bench/input_capture_frequency_meter_tb.sv
`timescale 1ns / 100ps

module input_capture_frequency_meter_tb;
    import icfm_pkg::*;

    localparam int CW       = 16;
    localparam int SETTLE   = 60;
    localparam int HOLD_LEN = 400;

    typedef struct packed {
        logic          ch;
        logic [CW-1:0] cnt;
    } capture_t;

    typedef struct packed {
        logic              ch;
        logic [CW-1:0]     period;
        logic [FREQ_W-1:0] freq;
        logic              err;
    } meas_t;

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_valid         = 1'b0;
    logic                  o_ready;
    logic [0:0]            i_channel       = '0;
    logic [CW-1:0]         i_capture_count = '0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  o_valid;
    logic                  i_ready         = 1'b0;
    logic [0:0]            o_out_channel;
    logic [CW-1:0]         o_period_ticks;
    logic [FREQ_W-1:0]     o_frequency_hz;
    logic                  o_divide_error;

    input_capture_frequency_meter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_channel       (i_channel),
        .i_capture_count (i_capture_count),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_channel   (o_out_channel),
        .o_period_ticks  (o_period_ticks),
        .o_frequency_hz  (o_frequency_hz),
        .o_divide_error  (o_divide_error)
    );

    capture_t pending_captures[$];
    meas_t    expected_meas[$];

    logic [CLOCK_W-1:0] cfg_clock_hz = CLOCK_HZ_RST;
    logic [PRESC_W-1:0] cfg_prescale = PRESC_RST;
    logic               chan_armed[2] = '{1'b0, 1'b0};
    logic [CW-1:0]      chan_first[2] = '{'0, '0};
    logic [CW-1:0]      last_cap[2]   = '{'0, '0};

    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    logic     hold_req = 1'b0;
    logic     hold_done = 1'b0;
    int       hold_left = 0;
    int       errors = 0;
    capture_t beat;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void note_error(string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch @%0t: %s", $time, msg);
    endfunction

    // Per-channel two-phase capture; second capture yields a measurement.
    function automatic void predict_measurement(logic ch, logic [CW-1:0] cap);
        logic [CW-1:0] first;
        logic [CW-1:0] period;
        meas_t         m;
        if (!chan_armed[ch]) begin
            chan_first[ch] = cap;
            chan_armed[ch] = 1'b1;
            return;
        end
        first = chan_first[ch];
        if (cap > first)
            period = cap - first;
        else
            period = (16'hFFFF - first) + cap;
        m.ch     = ch;
        m.period = period;
        if (period == 0 || cfg_prescale == 0) begin
            m.freq = '0;
            m.err  = 1'b1;
        end else begin
            m.freq = FREQ_W'((cfg_clock_hz / cfg_prescale) / period);
            m.err  = 1'b0;
        end
        chan_armed[ch] = 1'b0;
        expected_meas.push_back(m);
    endfunction

    function automatic void check_result();
        meas_t m;
        if (expected_meas.size() == 0) begin
            note_error($sformatf("unexpected beat ch=%0d period=%0d freq=%0d err=%0d",
                o_out_channel, o_period_ticks, o_frequency_hz, o_divide_error));
            return;
        end
        m = expected_meas.pop_front();
        if (o_out_channel !== m.ch)
            note_error($sformatf("channel exp %0d got %0d", m.ch, o_out_channel));
        if (o_period_ticks !== m.period)
            note_error($sformatf("period exp %0d got %0d", m.period, o_period_ticks));
        if (o_frequency_hz !== m.freq)
            note_error($sformatf("frequency exp %0d got %0d", m.freq, o_frequency_hz));
        if (o_divide_error !== m.err)
            note_error($sformatf("divide_error exp %0d got %0d", m.err, o_divide_error));
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                predict_measurement(i_channel, i_capture_count);
            if (!i_valid || o_ready) begin
                if (pending_captures.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    beat = pending_captures.pop_front();
                    i_valid         <= 1'b1;
                    i_channel       <= beat.ch;
                    i_capture_count <= beat.cnt;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                check_result();
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic queue_capture(logic ch, logic [CW-1:0] cnt);
        capture_t c;
        c.ch  = ch;
        c.cnt = cnt;
        last_cap[ch] = cnt;
        pending_captures.push_back(c);
    endtask

    // Mix of boundary counts, near-repeats (short periods) and full-range counts.
    task automatic queue_random(int n);
        logic          ch;
        logic [CW-1:0] cnt;
        for (int k = 0; k < n; k++) begin
            ch = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 7))
                0:       cnt = 16'h0000;
                1:       cnt = 16'hFFFF;
                2, 3:    cnt = last_cap[ch] + CW'($urandom_range(0, 4)) - 16'd2;
                default: cnt = CW'($urandom);
            endcase
            queue_capture(ch, cnt);
        end
    endtask

    task automatic wait_drained();
        while (pending_captures.size() > 0 || i_valid || expected_meas.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == REG_CLOCK_HZ)
            cfg_clock_hz = val[CLOCK_W-1:0];
        else if (idx == REG_PRESCALE)
            cfg_prescale = val[PRESC_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] clk_hz, logic [CFG_DATA_W-1:0] presc,
                             int send_pct, int recv_pct, int n, logic hold);
        wait_drained();
        write_reg(REG_CLOCK_HZ, clk_hz);
        write_reg(REG_PRESCALE, presc);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (hold)
            hold_req <= 1'b1;
        queue_random(n);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset configuration
        queue_capture(1'b0, 16'h0000);  queue_capture(1'b0, 16'hFFFF);  // longest period
        queue_capture(1'b1, 16'hFFFF);  queue_capture(1'b1, 16'h0000);  // zero period
        queue_capture(1'b0, 16'd100);   queue_capture(1'b0, 16'd101);   // one tick
        queue_capture(1'b1, 16'h1234);  queue_capture(1'b1, 16'h1234);  // equal captures
        queue_capture(1'b0, 16'hFFF0);  queue_capture(1'b0, 16'h0010);  // wrap
        queue_capture(1'b0, 16'd5);     queue_capture(1'b1, 16'd7);     // interleaved
        queue_capture(1'b1, 16'd1000);  queue_capture(1'b0, 16'h8000);
        queue_capture(1'b1, 16'hAAAA);  queue_capture(1'b1, 16'h5555);

        run_phase(28'd72000000, 28'd64, 0, 0, 300, 1'b0);
        run_phase(28'd200000000, 28'd1, 69, 0, 250, 1'b0);
        run_phase(28'hFFFFFFF, 28'hFFE0001, 0, 69, 250, 1'b0);
        run_phase(28'd1, 28'd65536, 12, 12, 250, 1'b0);
        run_phase(28'd0, 28'd3, 0, 0, 250, 1'b1);
        run_phase(28'd72000000, 28'd0, 69, 0, 150, 1'b0);
        run_phase(CFG_DATA_W'($urandom_range(1, 200000000)),
                  CFG_DATA_W'($urandom_range(1, 65536)), 0, 69, 150, 1'b0);
        run_phase(CFG_DATA_W'($urandom_range(1, 200000000)),
                  CFG_DATA_W'($urandom_range(1, 65536)), 12, 12, 150, 1'b0);
        run_phase(28'd72000000, 28'd64, 12, 12, 250, 1'b0);

        wait_drained();
        if (expected_meas.size() > 0)
            note_error($sformatf("%0d measurements never arrived", expected_meas.size()));
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: input_capture_frequency_meter.f
rtl/core/icfm_pkg.sv
rtl/core/icfm_div.sv
rtl/core/input_capture_frequency_meter.sv
bench/input_capture_frequency_meter_tb.sv
